FILE: rtl/apg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apg_pkg
// Shared constants and types of the arc polyline point generator.
// ----------------------------------------------------------------------------
package apg_pkg;

  // 2*3.14159 in Q7.16, the turn that circles and segment counts use.
  localparam int unsigned TWO_PI_FILE_Q16 = 411774;
  // True 2*pi in Q8.24 and pi/2 in Q2.30, used for phase and sine table.
  localparam longint unsigned TWO_PI_TRUE_Q24 = 64'd105414357;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam int COORD_MAX = 8388607;
  localparam int COORD_MIN = -8388608;

  typedef logic signed [23:0] coord_t;
  typedef logic signed [23:0] angle_t;

  // One vertex on its way through the point pipeline.
  typedef struct packed {
    angle_t      ang;
    coord_t      cx;
    coord_t      cy;
    logic [22:0] rad;
    logic [5:0]  idx;
    logic        last;
  } job_t;

endpackage

FILE: rtl/apg_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apg_req_if
// Request channel: one circle or arc request per handshake.
// ----------------------------------------------------------------------------
interface apg_req_if;
  logic              valid;
  logic              ready;
  logic              op;
  logic signed [23:0] center_x;
  logic signed [23:0] center_y;
  logic [22:0]       radius;
  logic signed [23:0] start_angle;
  logic signed [23:0] end_angle;

  modport source (output valid, op, center_x, center_y, radius, start_angle, end_angle,
                  input ready);
  modport sink (input valid, op, center_x, center_y, radius, start_angle, end_angle,
                output ready);
endinterface

FILE: rtl/apg_pt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apg_pt_if
// Point channel: one polyline vertex per handshake.
// ----------------------------------------------------------------------------
interface apg_pt_if;
  logic              valid;
  logic              ready;
  logic signed [23:0] point_x;
  logic signed [23:0] point_y;
  logic [5:0]        point_index;
  logic              last;

  modport source (output valid, point_x, point_y, point_index, last, input ready);
  modport sink (input valid, point_x, point_y, point_index, last, output ready);
endinterface

FILE: rtl/arc_polyline_point_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_polyline_point_generator
// Turns one circle or arc request into the vertices of a polyline.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake      Payload
// req_i    in   valid/ready    op, center_x, center_y, radius, start/end angle
// pt_o     out  valid/ready    point_x, point_y, point_index, last
//
// A request is accepted in ST_IDLE. An arc then works out its segment count
// (reciprocal estimate and one correction; a span at or past the saturation
// limit takes MAX_SEGMENTS at once) and divides the angle span by the count,
// one bit of the 25-bit quotient at a time; a circle uses a fixed step and
// skips both. Then n+1 vertices issue, one per cycle unless pt_o stalls.
// Vertices pass a six stage pipeline before they show on pt_o.
// Reset clears the sequencer and all valid bits. A stall on pt_o freezes the
// whole point pipeline and the vertex issue; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module arc_polyline_point_generator #(
  parameter int unsigned SEGMENTS_PER_TURN = 32,
  parameter int unsigned MAX_SEGMENTS      = 63,
  parameter int unsigned TRIG_TABLE_BITS   = 10
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  apg_req_if.sink  req_i,
  apg_pt_if.source pt_o
);
  import apg_pkg::*;

  localparam logic [5:0] SEG6  = 6'(SEGMENTS_PER_TURN);
  localparam logic [5:0] MAX6  = 6'(MAX_SEGMENTS);
  localparam logic [5:0] CIRCLE_N = (SEGMENTS_PER_TURN > MAX_SEGMENTS) ? MAX6 : SEG6;
  localparam logic [30:0] SAT_LIMIT = 31'(64 * TWO_PI_FILE_Q16);
  localparam logic [24:0] CIRCLE_Q = 25'(TWO_PI_FILE_Q16 / SEGMENTS_PER_TURN);
  localparam logic [5:0]  CIRCLE_R = 6'(TWO_PI_FILE_Q16 % SEGMENTS_PER_TURN);
  localparam int unsigned RECIP_SH = 32;
  localparam logic [13:0] RECIP_K  = 14'((64'd1 << RECIP_SH) / TWO_PI_FILE_Q16);
  localparam logic [18:0] K19      = 19'(TWO_PI_FILE_Q16);

  typedef enum logic [1:0] {ST_IDLE, ST_NCALC, ST_DIV, ST_GEN} state_e;

  state_e state_q;
  coord_t cx_q, cy_q;
  logic [22:0] rad_q;
  angle_t st_q;
  logic neg_q;
  logic [5:0] d_q, n_q, idx_q, racc_q, r_q;
  logic [4:0] cnt_q;
  logic [30:0] sm_q;
  logic [24:0] quo_q, qacc_q;

  logic signed [24:0] diff;
  logic [24:0] mag;
  logic [30:0] sm;
  logic [38:0] nprod;
  logic [5:0] nest;
  logic [30:0] trial;
  logic [5:0] nbits, nfin;
  logic [6:0] dtry;
  logic [6:0] rsum;
  logic carry;
  logic signed [25:0] qsgn;
  job_t job;
  logic job_ready;

  assign diff  = 25'(req_i.end_angle) - 25'(req_i.start_angle);
  assign mag   = diff[24] ? 25'(-diff) : 25'(diff);
  assign sm    = 31'(mag) * 31'(SEGMENTS_PER_TURN);
  // The reciprocal estimate is low by at most one segment.
  assign nprod = 39'(sm_q[24:0]) * 39'(RECIP_K);
  assign nest  = 6'(nprod >> RECIP_SH);
  assign trial = 31'({1'b0, n_q} + 7'd1) * 31'(K19);
  assign nbits = (sm_q >= trial) ? 6'(n_q + 6'd1) : n_q;
  always_comb begin
    nfin = (nbits == 6'd0) ? 6'd1 : nbits;
    if (nfin > MAX6) nfin = MAX6;
  end
  assign dtry  = {r_q, quo_q[24]};
  assign rsum  = {1'b0, racc_q} + {1'b0, r_q};
  assign carry = rsum >= {1'b0, d_q};
  assign qsgn  = neg_q ? -$signed({1'b0, qacc_q}) : $signed({1'b0, qacc_q});

  assign req_i.ready = (state_q == ST_IDLE);

  always_comb begin
    job.ang  = 24'(26'(st_q) + qsgn);
    job.cx   = cx_q;
    job.cy   = cy_q;
    job.rad  = rad_q;
    job.idx  = idx_q;
    job.last = (idx_q == n_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            cx_q  <= req_i.center_x;
            cy_q  <= req_i.center_y;
            rad_q <= req_i.radius;
            if (!req_i.op) begin
              // A full circle steps by a fixed fraction of a turn.
              st_q    <= '0;
              neg_q   <= 1'b0;
              quo_q   <= CIRCLE_Q;
              r_q     <= CIRCLE_R;
              d_q     <= SEG6;
              n_q     <= CIRCLE_N;
              qacc_q  <= '0;
              racc_q  <= '0;
              idx_q   <= '0;
              state_q <= ST_GEN;
            end else begin
              st_q  <= req_i.start_angle;
              neg_q <= diff[24];
              quo_q <= mag;
              sm_q  <= sm;
              r_q   <= '0;
              if (sm >= SAT_LIMIT) begin
                d_q     <= MAX6;
                n_q     <= MAX6;
                cnt_q   <= 5'd24;
                state_q <= ST_DIV;
              end else begin
                cnt_q   <= 5'd1;
                state_q <= ST_NCALC;
              end
            end
          end
        end
        ST_NCALC: begin
          // Estimate of the segment count first, then one correction step.
          if (cnt_q != 5'd0) begin
            n_q   <= nest;
            cnt_q <= cnt_q - 5'd1;
          end else begin
            n_q     <= nfin;
            d_q     <= nfin;
            cnt_q   <= 5'd24;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          // Restoring division of the angle span by the divisor.
          if (dtry >= {1'b0, d_q}) begin
            r_q   <= 6'(dtry - {1'b0, d_q});
            quo_q <= {quo_q[23:0], 1'b1};
          end else begin
            r_q   <= 6'(dtry);
            quo_q <= {quo_q[23:0], 1'b0};
          end
          if (cnt_q == 5'd0) begin
            qacc_q  <= '0;
            racc_q  <= '0;
            idx_q   <= '0;
            state_q <= ST_GEN;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        ST_GEN: begin
          if (job_ready) begin
            racc_q <= carry ? 6'(rsum - {1'b0, d_q}) : 6'(rsum);
            qacc_q <= qacc_q + quo_q + 25'(carry);
            idx_q  <= idx_q + 6'd1;
            if (idx_q == n_q) state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  apg_point_pipe #(
    .TRIG_TABLE_BITS(TRIG_TABLE_BITS)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (state_q == ST_GEN),
    .job_i       (job),
    .job_ready_o (job_ready),
    .pt_o        (pt_o)
  );

`ifndef ASSERT_OFF
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q != ST_IDLE))
    else $error("request accepted but sequencer stayed idle");
  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GEN) |-> (idx_q <= n_q))
    else $error("vertex index ran past the segment count");
  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GEN) |-> (d_q != 6'd0 && n_q != 6'd0))
    else $error("zero divisor or segment count");
  a_gen_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GEN && job_ready && idx_q != n_q) |=> (state_q == ST_GEN))
    else $error("vertex issue ended early");
`endif

endmodule

FILE: rtl/apg_point_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apg_point_pipe
// Angle to vertex pipeline: phase, sine table lookup, scale and offset.
// ----------------------------------------------------------------------------
module apg_point_pipe #(
  parameter int unsigned TRIG_TABLE_BITS = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  apg_pkg::job_t job_i,
  output logic          job_ready_o,
  apg_pt_if.source      pt_o
);
  import apg_pkg::*;

  localparam int unsigned T       = TRIG_TABLE_BITS;
  localparam int unsigned ROM_LEN = (1 << T) + 1;
  localparam int unsigned SH      = 40 - T;
  localparam longint unsigned DIV2 = 2 * TWO_PI_TRUE_Q24;
  localparam longint unsigned KREC = (64'd1 << (T + 11 + SH)) / DIV2;
  localparam logic [24:0] K25 = 25'(KREC);
  localparam logic [27:0] D28 = 28'(DIV2);

  typedef logic [16:0] rom_t [ROM_LEN];

  function automatic rom_t build_rom();
    rom_t r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    for (int k = 0; k < ROM_LEN; k++) begin
      x    = (64'(k) * HALF_PI_Q30) >> T;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      r[k] = 17'((64'(sum) + 64'd8192) >> 14);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // Table index of a quarter-wave lookup, mirrored in odd quadrants.
  function automatic logic [T:0] rom_index(input logic [T+1:0] p);
    logic [T:0] r;
    r = {1'b0, p[T-1:0]};
    return p[T] ? ((T+1)'(1) << T) - r : r;
  endfunction

  logic en;
  assign en          = !pt_o.valid || pt_o.ready;
  assign job_ready_o = en;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  job_t j1_q, j2_q, j3_q, j4_q, j5_q;

  // Stage 1: reciprocal product and exact numerator of the phase.
  logic signed [48:0] prod1_q;
  logic signed [55:0] num1_q;
  // Stage 2: phase estimate and the divisor times estimate plus one.
  logic signed [23:0] qe2_q;
  logic signed [55:0] mul2_q;
  logic signed [55:0] num2_q;
  // Stage 3: phase.
  logic [T+1:0]       ph3_q;
  // Stage 4: table reads.
  logic [16:0]        sin4_q, cos4_q;
  logic               sneg4_q, cneg4_q;
  // Stage 5: scaled offsets.
  logic signed [41:0] px5_q, py5_q;

  logic signed [48:0] prod1_d;
  logic signed [55:0] num1_d;
  logic signed [48:0] qsh;
  logic signed [23:0] qe2_d;
  logic signed [24:0] qp1_2, qp1_3;
  logic signed [53:0] mul2_w;
  logic [T+1:0]       ph_cos;
  logic signed [17:0] trig_s, trig_c;
  logic signed [25:0] offx, offy;
  logic signed [26:0] vx, vy;
  logic signed [23:0] satx, saty;

  assign prod1_d = $signed(job_i.ang) * $signed(K25);
  assign num1_d  = ($signed(56'($signed(job_i.ang))) <<< (T + 11)) + 56'(TWO_PI_TRUE_Q24);

  assign qsh    = prod1_q >>> SH;
  assign qe2_d  = 24'(qsh);
  assign qp1_2  = 25'(qe2_d) + 25'sd1;
  assign mul2_w = qp1_2 * $signed({1'b0, D28});

  assign qp1_3  = 25'(qe2_q) + 25'sd1;
  assign ph_cos = ph3_q + ((T+2)'(1) << T);

  assign trig_s = sneg4_q ? -$signed({1'b0, sin4_q}) : $signed({1'b0, sin4_q});
  assign trig_c = cneg4_q ? -$signed({1'b0, cos4_q}) : $signed({1'b0, cos4_q});

  assign offx = 26'((px5_q + 42'sd32768) >>> 16);
  assign offy = 26'((py5_q + 42'sd32768) >>> 16);
  assign vx   = 27'(j5_q.cx) + 27'(offx);
  assign vy   = 27'(j5_q.cy) + 27'(offy);

  always_comb begin
    if (vx > 27'(COORD_MAX)) satx = 24'(COORD_MAX);
    else if (vx < 27'(COORD_MIN)) satx = 24'(COORD_MIN);
    else satx = 24'(vx);
    if (vy > 27'(COORD_MAX)) saty = 24'(COORD_MAX);
    else if (vy < 27'(COORD_MIN)) saty = 24'(COORD_MIN);
    else saty = 24'(vy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      v4_q       <= 1'b0;
      v5_q       <= 1'b0;
      pt_o.valid <= 1'b0;
    end else if (en) begin
      v1_q       <= job_valid_i;
      v2_q       <= v1_q;
      v3_q       <= v2_q;
      v4_q       <= v3_q;
      v5_q       <= v4_q;
      pt_o.valid <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      j1_q    <= job_i;
      prod1_q <= prod1_d;
      num1_q  <= num1_d;

      j2_q    <= j1_q;
      qe2_q   <= qe2_d;
      mul2_q  <= 56'(mul2_w);
      num2_q  <= num1_q;

      // The estimate is low by at most one; the compare settles it.
      j3_q    <= j2_q;
      ph3_q   <= (num2_q >= mul2_q) ? (T+2)'(qp1_3) : (T+2)'(qe2_q);

      j4_q    <= j3_q;
      sin4_q  <= SINE_ROM[rom_index(ph3_q)];
      cos4_q  <= SINE_ROM[rom_index(ph_cos)];
      sneg4_q <= ph3_q[T+1];
      cneg4_q <= ph_cos[T+1];

      j5_q    <= j4_q;
      px5_q   <= $signed({1'b0, j4_q.rad}) * trig_c;
      py5_q   <= $signed({1'b0, j4_q.rad}) * trig_s;

      pt_o.point_x     <= satx;
      pt_o.point_y     <= saty;
      pt_o.point_index <= j5_q.idx;
      pt_o.last        <= j5_q.last;
    end
  end

endmodule
